### src/slip_rx_pkg.sv
// Shared constants and types for the SLIP packet receiver.
`default_nettype none

package slip_rx_pkg;

   localparam int PAYLOAD_BYTES = 4;
   localparam int IDX_WIDTH     = $clog2(PAYLOAD_BYTES);
   localparam int COUNT_WIDTH   = 3;

   localparam logic [7:0] CODE_END     = 8'hC0;
   localparam logic [7:0] CODE_ESC     = 8'hDB;
   localparam logic [7:0] CODE_ESC_END = 8'hDC;
   localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

   typedef struct packed {
      logic [15:0]            device_number;
      logic [15:0]            sample_value;
      logic [COUNT_WIDTH-1:0] byte_count;
      logic                   frame_overflow;
   } record_type;

endpackage

`default_nettype wire

### src/slip_packet_receiver.sv
// Usage notes: the SLIP packet receiver takes one raw serial byte per
// request beat and returns one record per frame on the response channel.
// Request and response channels use valid and ready; a beat moves when both
// are high. Bytes are ignored until the first END byte, which synchronizes
// the receiver without producing a record. Each later unescaped END
// produces a record with the device number, sample value, kept byte count
// and overflow flag. An accepted byte waits in the input register until the
// decoder steps on it; an END's record then enters the result register.
// Unless the response side is stalled the block takes one byte every cycle;
// the two registers separate the sides, so a byte is still accepted while
// a record waits. When the receiver holds rsp_ready low with a record
// pending, the input register fills and req_ready falls after one more
// byte. Reset clears the frame state, the sync flag and both valid flags.
`default_nettype none

module slip_packet_receiver
   import slip_rx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [15:0]                 rsp_device_number,
   output logic [15:0]                 rsp_sample_value,
   output logic [COUNT_WIDTH-1:0]      rsp_byte_count,
   output logic                        rsp_frame_overflow
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   record_type out_record_ff;
   logic       out_free;
   logic       step;
   logic       emit;
   record_type record;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   slip_rx_dec u_dec (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .record  (record)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (emit) begin
         out_record_ff <= record;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_device_number  = out_record_ff.device_number;
   assign rsp_sample_value   = out_record_ff.sample_value;
   assign rsp_byte_count     = out_record_ff.byte_count;
   assign rsp_frame_overflow = out_record_ff.frame_overflow;

endmodule

`default_nettype wire

### src/slip_rx_dec.sv
// SLIP frame decoder: sync, escape and payload state, one beat per step.
`default_nettype none

module slip_rx_dec
   import slip_rx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            emit,
   output record_type      record
);

   logic [7:0]             store_ff [PAYLOAD_BYTES];
   logic [7:0]             store_in [PAYLOAD_BYTES];
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   synced_ff, synced_in;
   logic                   escape_ff, escape_in;
   logic                   overflow_ff, overflow_in;
   logic [7:0]             data_byte;
   logic                   keep;
   logic                   clear;

   always_comb begin
      if (rx_byte == CODE_ESC_END) begin
         data_byte = CODE_END;
      end else if (rx_byte == CODE_ESC_ESC) begin
         data_byte = CODE_ESC;
      end else begin
         data_byte = rx_byte;
      end
   end

   always_comb begin
      emit      = 1'b0;
      keep      = 1'b0;
      clear     = 1'b0;
      synced_in = synced_ff;
      escape_in = escape_ff;
      if (step) begin
         if (!synced_ff) begin
            if (rx_byte == CODE_END) begin
               synced_in = 1'b1;
               clear     = 1'b1;
               escape_in = 1'b0;
            end
         end else if (escape_ff) begin
            escape_in = 1'b0;
            keep      = 1'b1;
         end else if (rx_byte == CODE_ESC) begin
            escape_in = 1'b1;
         end else if (rx_byte == CODE_END) begin
            emit      = 1'b1;
            clear     = 1'b1;
            escape_in = 1'b0;
         end else begin
            keep = 1'b1;
         end
      end
   end

   always_comb begin
      store_in    = store_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (clear) begin
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            store_in[i] = 8'h00;
         end
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (keep) begin
         if (count_ff < COUNT_WIDTH'(PAYLOAD_BYTES)) begin
            store_in[count_ff[IDX_WIDTH-1:0]] = escape_ff ? data_byte : rx_byte;
            count_in = count_ff + 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            store_ff[i] <= 8'h00;
         end
         count_ff    <= '0;
         synced_ff   <= 1'b0;
         escape_ff   <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         store_ff    <= store_in;
         count_ff    <= count_in;
         synced_ff   <= synced_in;
         escape_ff   <= escape_in;
         overflow_ff <= overflow_in;
      end
   end

   assign record.device_number  = {store_ff[0], store_ff[1]};
   assign record.sample_value   = {store_ff[2], store_ff[3]};
   assign record.byte_count     = count_ff;
   assign record.frame_overflow = overflow_ff;

endmodule

`default_nettype wire
